// ----- rtl/ptts_pkg.sv -----
// package for the periodic task tick scheduler
// beat types, command/status structs and codes shared by all rtl files
package ptts_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int SLOT_IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int DIV_W      = 16;
	localparam int PERIOD_W   = 16;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [DIV_W-1:0] TICKS_RESET = 16'd1;

	// input command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_CREATE = 1'b1;

	// result kind codes
	localparam logic KIND_CREATE = 1'b0;
	localparam logic KIND_FIRE   = 1'b1;

	// status codes
	localparam logic STATUS_OK           = 1'b0;
	localparam logic STATUS_NULL_HANDLER = 1'b1;

	// register word index
	localparam logic REG_TICKS_PER_STEP = 1'b0;

	typedef struct packed {
		logic                cmd;
		logic [2:0]          slot;
		logic [PERIOD_W-1:0] period;
		logic                has_handler;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic       status;
		logic [2:0] task_slot;
		logic       last;
	} evt_t;

	// controller to datapath
	typedef struct packed {
		logic req_latch;
		logic create_do;
		logic tick_step;
		logic scan_start;
		logic scan_do;
	} ptts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_create;
		logic div_hit;
		logic out_free;
		logic fire_here;
		logic scan_end;
	} ptts_sts_t;

endpackage

// ----- rtl/ptts_ctrl.sv -----
// controller state machine for the periodic task tick scheduler
// depends on ptts_pkg; drives ptts_dp through command/status structs
module ptts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ptts_pkg::ptts_sts_t sts,
	output ptts_pkg::ptts_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   req_ready_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && req_ready_q) begin
					cmd.req_latch = 1'b1;
					state_nxt     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_create) begin
					if (sts.out_free) begin
						cmd.create_do = 1'b1;
						state_nxt     = ST_IDLE;
					end
				end else begin
					cmd.tick_step = 1'b1;
					if (sts.div_hit) begin
						cmd.scan_start = 1'b1;
						state_nxt      = ST_SCAN;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_SCAN: begin
				// a firing slot waits for room in the output register
				if (!sts.fire_here || sts.out_free) begin
					cmd.scan_do = 1'b1;
					if (sts.scan_end) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_ready_q <= 1'b1;
		end else begin
			state_q     <= state_nxt;
			req_ready_q <= (state_nxt == ST_IDLE);
		end
	end

	assign req_ready = req_ready_q;

endmodule

// ----- rtl/ptts_dp.sv -----
// datapath for the periodic task tick scheduler: item latch, step divider,
// slot table, scan index and output register; depends on ptts_pkg
module ptts_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ptts_pkg::req_t                     req,
	input  logic                               cfg_wr,
	input  logic [ptts_pkg::DIV_W-1:0]         cfg_wdata,
	output logic [ptts_pkg::DIV_W-1:0]         ticks_per_step,
	input  ptts_pkg::ptts_cmd_t                cmd,
	output ptts_pkg::ptts_sts_t                sts,
	output logic                               evt_valid,
	input  logic                               evt_ready,
	output ptts_pkg::evt_t                     evt
);

	ptts_pkg::req_t                       item_q;
	logic [ptts_pkg::DIV_W-1:0]           tps_q;
	logic [ptts_pkg::DIV_W-1:0]           div_q;
	logic [ptts_pkg::TASK_SLOTS-1:0]      valid_q;
	logic [ptts_pkg::PERIOD_W-1:0]        period_q [ptts_pkg::TASK_SLOTS];
	logic [ptts_pkg::PERIOD_W-1:0]        cdown_q  [ptts_pkg::TASK_SLOTS];
	logic [ptts_pkg::TASK_SLOTS-1:0]      fire_mask_q;
	logic [ptts_pkg::SLOT_IDX_W-1:0]      idx_q;
	ptts_pkg::evt_t                       evt_q;
	logic                                 evt_valid_q;

	logic [ptts_pkg::TASK_SLOTS-1:0]      fire_now;
	logic [ptts_pkg::TASK_SLOTS-1:0]      mask_above;
	logic                                 slot_in_range;
	logic [ptts_pkg::SLOT_IDX_W-1:0]      wr_idx;
	logic                                 create_wr;
	logic                                 fire_emit;
	logic                                 out_free;

	always_comb begin
		for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
			fire_now[i] = valid_q[i] && (cdown_q[i] == '0);
		end
	end

	assign mask_above    = (fire_mask_q >> idx_q) >> 1;
	assign slot_in_range = (32'(item_q.slot) < ptts_pkg::TASK_SLOTS);
	assign wr_idx        = ptts_pkg::SLOT_IDX_W'(item_q.slot);
	assign create_wr     = cmd.create_do && item_q.has_handler && slot_in_range;
	assign fire_emit     = cmd.scan_do && fire_mask_q[idx_q];
	assign out_free      = !evt_valid_q || evt_ready;

	assign sts.is_create = (item_q.cmd == ptts_pkg::CMD_CREATE);
	assign sts.div_hit   = (div_q == ptts_pkg::DIV_W'(1));
	assign sts.out_free  = out_free;
	assign sts.fire_here = fire_mask_q[idx_q];
	assign sts.scan_end  = (idx_q == ptts_pkg::SLOT_IDX_W'(ptts_pkg::TASK_SLOTS - 1));

	always_ff @(posedge clk) begin
		if (cmd.req_latch) begin
			item_q <= req;
		end
	end

	// divider and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= ptts_pkg::TICKS_RESET;
			div_q <= ptts_pkg::TICKS_RESET;
		end else if (cfg_wr) begin
			tps_q <= cfg_wdata;
			div_q <= cfg_wdata;
		end else if (cmd.tick_step) begin
			div_q <= sts.div_hit ? tps_q : div_q - ptts_pkg::DIV_W'(1);
		end
	end

	// slot table: valid marks reset, period and countdown do not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (create_wr) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (create_wr) begin
			period_q[wr_idx] <= item_q.period;
			cdown_q[wr_idx]  <= item_q.period - ptts_pkg::PERIOD_W'(1);
		end else if (cmd.scan_do) begin
			if (fire_mask_q[idx_q]) begin
				cdown_q[idx_q] <= period_q[idx_q] - ptts_pkg::PERIOD_W'(1);
			end else begin
				cdown_q[idx_q] <= cdown_q[idx_q] - ptts_pkg::PERIOD_W'(1);
			end
		end
	end

	// scan index and snapshot of the slots due this step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			fire_mask_q <= '0;
		end else if (cmd.scan_start) begin
			idx_q       <= '0;
			fire_mask_q <= fire_now;
		end else if (cmd.scan_do) begin
			idx_q <= idx_q + ptts_pkg::SLOT_IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (cmd.create_do || fire_emit) begin
			evt_valid_q <= 1'b1;
		end else if (evt_ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create_do) begin
			evt_q.kind      <= ptts_pkg::KIND_CREATE;
			evt_q.status    <= item_q.has_handler ? ptts_pkg::STATUS_OK
			                                      : ptts_pkg::STATUS_NULL_HANDLER;
			evt_q.task_slot <= item_q.slot;
			evt_q.last      <= 1'b1;
		end else if (fire_emit) begin
			evt_q.kind      <= ptts_pkg::KIND_FIRE;
			evt_q.status    <= ptts_pkg::STATUS_OK;
			evt_q.task_slot <= 3'(idx_q);
			evt_q.last      <= (mask_above == '0);
		end
	end

	assign evt_valid      = evt_valid_q;
	assign evt            = evt_q;
	assign ticks_per_step = tps_q;

endmodule

// ----- rtl/periodic_task_tick_scheduler_core.sv -----
// periodic task tick scheduler, top level: apb register port, controller and datapath
// a create answers with one status beat; a tick that ends a step scans the slots in
// order, one slot a cycle, a firing slot waiting for room in the output register
// one item at a time: req_ready stays low until the controller is back in idle
// reset: arst_n async, clears slot valid marks, loads ticks_per_step and divider with 1
module periodic_task_tick_scheduler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ptts_pkg::req_t                req,
	// event channel
	output logic                          evt_valid,
	input  logic                          evt_ready,
	output ptts_pkg::evt_t                evt,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptts_pkg::PADDR_W-1:0]  paddr,
	input  logic [ptts_pkg::PDATA_W-1:0]  pwdata,
	output logic [ptts_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	ptts_pkg::ptts_cmd_t          cmd;
	ptts_pkg::ptts_sts_t          sts;
	logic                         cfg_wr;
	logic                         reg_hit;
	logic [ptts_pkg::DIV_W-1:0]   ticks_per_step;

	// one register at word 0, byte lanes ignored; other words read as zero
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == ptts_pkg::REG_TICKS_PER_STEP);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? ptts_pkg::PDATA_W'(ticks_per_step) : '0;

	// controller: idle, decode of the latched item, slot scan
	ptts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: slot table, divider, scan index and event output register
	ptts_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.cfg_wr         (cfg_wr),
		.cfg_wdata      (pwdata[ptts_pkg::DIV_W-1:0]),
		.ticks_per_step (ticks_per_step),
		.cmd            (cmd),
		.sts            (sts),
		.evt_valid      (evt_valid),
		.evt_ready      (evt_ready),
		.evt            (evt)
	);

	// one item at a time: the beat just taken blocks the next one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in progress");

	// a create status beat is always the only and final beat of its item
	a_create_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt.kind == ptts_pkg::KIND_CREATE) |-> evt.last)
		else $error("create status beat without last");

	// fire beats never carry an error status
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt.kind == ptts_pkg::KIND_FIRE) |-> (evt.status == ptts_pkg::STATUS_OK))
		else $error("fire beat with error status");

	// a new event beat appears only while the controller is busy or just finishing
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(evt_valid) |-> $past(!req_ready))
		else $error("event beat produced while idle");

endmodule

// ----- verif/tb_periodic_task_tick_scheduler_core.sv -----
// self-checking testbench for periodic_task_tick_scheduler_core
// depends on ptts_pkg (beat structs, codes, sizes) and the core rtl; nothing else
module tb_periodic_task_tick_scheduler_core;

	// most fire beats one tick can cause
	localparam int FIRE_MAX      = 8;
	// quiet cycles after the last expected beat, enough to cover a full silent scan
	localparam int SETTLE_CYCLES = 24;
	// cycles without any accepted beat before the run is declared hung
	localparam int HANG_LIMIT    = 2000;
	// register 0 sits at byte address 0
	localparam logic [ptts_pkg::PADDR_W-1:0] ADDR_TICKS = {ptts_pkg::REG_TICKS_PER_STEP, 2'b00};

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         req_valid = 1'b0;
	logic                         req_ready;
	ptts_pkg::req_t               req       = '0;
	logic                         evt_valid;
	logic                         evt_ready = 1'b0;
	ptts_pkg::evt_t               evt;
	logic                         psel      = 1'b0;
	logic                         penable   = 1'b0;
	logic                         pwrite    = 1'b0;
	logic [ptts_pkg::PADDR_W-1:0] paddr     = '0;
	logic [ptts_pkg::PDATA_W-1:0] pwdata    = '0;
	logic [ptts_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	periodic_task_tick_scheduler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// request beats waiting to go out, and event beats the scheduler owes us
	ptts_pkg::req_t req_backlog[$];
	ptts_pkg::evt_t expected_evts[$];
	ptts_pkg::evt_t oldest_evt;

	// our own copy of the scheduler state
	logic [ptts_pkg::DIV_W-1:0]    ticks_cfg;
	logic [ptts_pkg::DIV_W-1:0]    divider;
	logic                          slot_live  [ptts_pkg::TASK_SLOTS];
	logic [ptts_pkg::PERIOD_W-1:0] slot_per   [ptts_pkg::TASK_SLOTS];
	logic [ptts_pkg::PERIOD_W-1:0] slot_count [ptts_pkg::TASK_SLOTS];

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic req_taken     = 1'b0;
	int   mismatches    = 0;
	int   idle_cycles   = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic ptts_pkg::req_t create_req(input logic [2:0] slot,
			input logic [ptts_pkg::PERIOD_W-1:0] period, input logic handler);
		ptts_pkg::req_t r;
		r.cmd         = ptts_pkg::CMD_CREATE;
		r.slot        = slot;
		r.period      = period;
		r.has_handler = handler;
		return r;
	endfunction

	// slot, period and handler mean nothing on a tick, so they carry noise
	function automatic ptts_pkg::req_t tick_req();
		ptts_pkg::req_t r;
		r.cmd         = ptts_pkg::CMD_TICK;
		r.slot        = 3'($urandom_range(0, 7));
		r.period      = ptts_pkg::PERIOD_W'($urandom_range(0, 65535));
		r.has_handler = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// mostly ticks and short periods so tasks fire often; now and then a long
	// period or a null handler
	function automatic ptts_pkg::req_t random_req();
		logic [ptts_pkg::PERIOD_W-1:0] period;
		if ($urandom_range(0, 99) < 60)
			return tick_req();
		if ($urandom_range(0, 9) < 7)
			period = ptts_pkg::PERIOD_W'($urandom_range(0, 6));
		else
			period = ptts_pkg::PERIOD_W'($urandom_range(0, 65535));
		return create_req(3'($urandom_range(0, 7)), period, $urandom_range(0, 9) != 0);
	endfunction

	// works out the event beats one request causes and queues them
	function automatic void schedule_events(input ptts_pkg::req_t r);
		ptts_pkg::evt_t e;
		ptts_pkg::evt_t held;
		logic have_held;
		int   n;
		e         = '0;
		held      = '0;
		have_held = 1'b0;
		n         = 0;
		if (r.cmd == ptts_pkg::CMD_CREATE) begin
			e.kind      = ptts_pkg::KIND_CREATE;
			e.task_slot = r.slot;
			e.last      = 1'b1;
			if (r.has_handler == 1'b0) begin
				// null handler: rejected, slot left alone
				e.status = ptts_pkg::STATUS_NULL_HANDLER;
			end else begin
				e.status = ptts_pkg::STATUS_OK;
				if (r.slot < ptts_pkg::TASK_SLOTS) begin
					slot_live[r.slot]  = 1'b1;
					slot_per[r.slot]   = r.period;
					slot_count[r.slot] = r.period - 1'b1;
				end
			end
			expected_evts.push_back(e);
		end else begin
			divider = divider - 1'b1;
			if (divider == '0) begin
				divider = ticks_cfg;
				// scan in priority order; the previous fire is held back so the
				// final one can carry last
				for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
					if (slot_live[i] && slot_count[i] == '0) begin
						slot_count[i] = slot_per[i] - 1'b1;
						if (n < FIRE_MAX) begin
							if (have_held)
								expected_evts.push_back(held);
							held.kind      = ptts_pkg::KIND_FIRE;
							held.status    = ptts_pkg::STATUS_OK;
							held.task_slot = 3'(i);
							held.last      = 1'b0;
							have_held      = 1'b1;
							n++;
						end
					end else begin
						// wraps, so a period of 0 behaves as 65536
						slot_count[i] = slot_count[i] - 1'b1;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					expected_evts.push_back(held);
				end
			end
		end
	endfunction

	// request driver and event back-pressure, both moved on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!(req_valid && !req_taken)) begin
			// previous beat gone, or none out: maybe send the next one
			if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req       <= req_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		evt_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor: checks event beats, feeds accepted requests and register writes
	// into the prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && req_ready;
			if (evt_valid && evt_ready) begin
				if (expected_evts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected event beat: kind %0d status %0d slot %0d last %0d",
							evt.kind, evt.status, evt.task_slot, evt.last);
				end else begin
					oldest_evt = expected_evts.pop_front();
					if (evt.kind !== oldest_evt.kind || evt.status !== oldest_evt.status ||
							evt.task_slot !== oldest_evt.task_slot ||
							evt.last !== oldest_evt.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"event mismatch: expected kind %0d status %0d slot %0d ",
								"last %0d, got kind %0d status %0d slot %0d last %0d"},
								oldest_evt.kind, oldest_evt.status, oldest_evt.task_slot,
								oldest_evt.last, evt.kind, evt.status, evt.task_slot,
								evt.last);
					end
				end
			end
			if (req_valid && req_ready)
				schedule_events(req);
			// a write to ticks_per_step also reloads the divider
			if (psel && penable && pwrite && pready && paddr == ADDR_TICKS) begin
				ticks_cfg = pwdata[ptts_pkg::DIV_W-1:0];
				divider   = pwdata[ptts_pkg::DIV_W-1:0];
			end
		end
	end

	// hang detection: any accepted beat or register access resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (evt_valid && evt_ready) ||
					(psel && penable && pready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic write_ticks(input logic [ptts_pkg::DIV_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TICKS;
		pwdata  <= {{(ptts_pkg::PDATA_W-ptts_pkg::DIV_W){1'b0}}, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until every request is out and every owed beat has arrived, then let
	// a possible silent scan finish
	task automatic settle();
		@(posedge clk);
		while (req_backlog.size() != 0 || req_valid || expected_evts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		ticks_cfg = ptts_pkg::TICKS_RESET;
		divider   = ptts_pkg::TICKS_RESET;
		for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
			slot_live[i]  = 1'b0;
			// never visible before a create writes them
			slot_per[i]   = '0;
			slot_count[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, one step per tick
		send_idle_pct = 10;
		recv_idle_pct = 68;
		write_ticks(16'd1);
		// step with no valid slot gives nothing
		req_backlog.push_back(tick_req());
		req_backlog.push_back(create_req(3'd0, 16'd1, 1'b1));
		// null handler is rejected
		req_backlog.push_back(create_req(3'd7, 16'hFFFF, 1'b0));
		req_backlog.push_back(create_req(3'd7, 16'hFFFF, 1'b1));
		req_backlog.push_back(tick_req());
		req_backlog.push_back(create_req(3'd3, 16'd2, 1'b1));
		// period 0 counts as 65536
		req_backlog.push_back(create_req(3'd5, 16'd0, 1'b1));
		repeat (3) req_backlog.push_back(tick_req());
		// replace a live task, then a null handler on a live slot
		req_backlog.push_back(create_req(3'd0, 16'd3, 1'b1));
		req_backlog.push_back(create_req(3'd3, 16'd5, 1'b0));
		repeat (2) req_backlog.push_back(tick_req());
		// every slot fires in one step
		for (int s = 0; s < ptts_pkg::TASK_SLOTS; s++)
			req_backlog.push_back(create_req(3'(s), 16'd1, 1'b1));
		req_backlog.push_back(tick_req());
		settle();

		// random phases with changing stall patterns and step lengths
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 68;
					write_ticks(16'd3);
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 10;
					write_ticks(16'd2);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					write_ticks(ptts_pkg::DIV_W'($urandom_range(1, 4)));
				end
			endcase
			repeat (30) req_backlog.push_back(random_req());
			settle();
		end

		// largest step length: a few ticks do not end a step
		write_ticks(16'hFFFF);
		req_backlog.push_back(create_req(3'd2, 16'd1, 1'b1));
		repeat (2) req_backlog.push_back(tick_req());
		settle();

		// zero step length: divider wraps to 65535, so no step ends soon
		write_ticks(16'd0);
		req_backlog.push_back(create_req(3'd6, 16'd1, 1'b1));
		repeat (2) req_backlog.push_back(tick_req());
		settle();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ptts_pkg.sv
rtl/ptts_ctrl.sv
rtl/ptts_dp.sv
rtl/periodic_task_tick_scheduler_core.sv
verif/tb_periodic_task_tick_scheduler_core.sv
